[hdl/ers_pkg.sv]
// ----------------------------------------------------------------------------
// ers_pkg
// Shared types and constants for the emboss relief shading core.
// ----------------------------------------------------------------------------
package ers_pkg;

  localparam int unsigned DIV_STEPS  = 56;
  localparam int unsigned SQRT_STEPS = 28;
  localparam logic [16:0] GAIN_ONE   = 17'd65536;

  typedef enum logic [1:0] {
    REG_GAIN    = 2'd0,
    REG_LIGHT_X = 2'd1,
    REG_LIGHT_Y = 2'd2,
    REG_LIGHT_Z = 2'd3
  } reg_index_t;

  // payload carried alongside each pixel through the pipe
  typedef struct packed {
    logic            facing;
    logic [2:0][7:0] chan;
  } side_t;

endpackage

[hdl/emboss_relief_shading_core.sv]
// ----------------------------------------------------------------------------
// emboss_relief_shading_core
// Pipelined emboss relief shading: normal from height gradients, Lambert
// intensity against a programmable light, gain blend of the pixel colour.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel request is taken on every rising edge with start high; busy is
//   always low, so a new pixel may follow every cycle.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data) and
//   is taken at once; write it only while no pixel is in flight.
//   The result appears on out_red/out_green/out_blue/facing_light with done
//   high for one cycle, once the request has passed the gradient stages, the
//   divider, the square root unit and the blend stages.
//   Throughput is one pixel per clock. Latency is set by the quotient
//   unit (56 restoring division stages, one quotient bit each) and the
//   square root unit (28 stages, one root bit each), plus seven stages of
//   gradient, multiply and blend logic.
//   Reset clears all valid bits and loads gain 0.5 and light (0, 0, 1).
//   The receiver cannot stall: done is a strobe and the pipe never waits.
// ----------------------------------------------------------------------------
module emboss_relief_shading_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  height_left,
  input  logic [7:0]  height_right,
  input  logic [7:0]  height_up,
  input  logic [7:0]  height_down,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output logic        done,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        facing_light
);

  localparam int unsigned ND = ers_pkg::DIV_STEPS;
  localparam int unsigned NS = ers_pkg::SQRT_STEPS;

  logic [16:0]        emboss_gain;
  logic signed [15:0] light_x;
  logic signed [15:0] light_y;
  logic signed [15:0] light_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      emboss_gain <= 17'd32768;
      light_x     <= '0;
      light_y     <= '0;
      light_z     <= 16'sd16384;
    end else if (cfg_write) begin
      unique case (ers_pkg::reg_index_t'(cfg_index))
        ers_pkg::REG_GAIN:    emboss_gain <= cfg_data;
        ers_pkg::REG_LIGHT_X: light_x     <= $signed(cfg_data[15:0]);
        ers_pkg::REG_LIGHT_Y: light_y     <= $signed(cfg_data[15:0]);
        ers_pkg::REG_LIGHT_Z: light_z     <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: gradients
  logic               s0_valid;
  logic signed [8:0]  s0_dx, s0_dy;
  logic [2:0][7:0]    s0_chan;

  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else     s0_valid <= start;
  end

  always_ff @(posedge clk) begin
    s0_dx   <= $signed({1'b0, height_left}) - $signed({1'b0, height_right});
    s0_dy   <= $signed({1'b0, height_up}) - $signed({1'b0, height_down});
    s0_chan <= {in_blue, in_green, in_red};
  end

  // stage 1: light products and squares
  logic               s1_valid;
  logic signed [24:0] s1_px, s1_py;
  logic signed [17:0] s1_sqx, s1_sqy;
  logic [2:0][7:0]    s1_chan;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= s0_valid;
  end

  always_ff @(posedge clk) begin
    s1_px   <= s0_dx * light_x;
    s1_py   <= s0_dy * light_y;
    s1_sqx  <= s0_dx * s0_dx;
    s1_sqy  <= s0_dy * s0_dy;
    s1_chan <= s0_chan;
  end

  // stage 2: normal numerator, sign and denominator factors
  logic               s2_valid;
  logic [27:0]        s2_v;
  logic [16:0]        s2_pa, s2_pb;
  ers_pkg::side_t     s2_side;
  logic signed [27:0] nint;

  always_comb begin
    nint = (28'(light_z) <<< 2) - (28'(s1_px) <<< 1) - (28'(s1_py) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    s2_v           <= nint[27] ? 28'd0 : {nint[25:0], 2'b00};
    s2_pa          <= 17'(s1_sqx[15:0]) + 17'd4;
    s2_pb          <= 17'(s1_sqy[15:0]) + 17'd4;
    s2_side.facing <= ~nint[27];
    s2_side.chan   <= s1_chan;
  end

  // stage 3: dividend and divisor
  logic           s3_valid;
  logic [55:0]    s3_vsq;
  logic [31:0]    s3_p;
  ers_pkg::side_t s3_side;
  logic [33:0]    p_full;

  assign p_full = 34'(s2_pa) * 34'(s2_pb);

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else     s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    s3_vsq  <= 56'(s2_v) * 56'(s2_v);
    s3_p    <= p_full[31:0];
    s3_side <= s2_side;
  end

  // restoring divider, one quotient bit per stage
  logic           d_valid [0:ND];
  logic [31:0]    d_rem   [0:ND];
  logic [55:0]    d_num   [0:ND];
  logic [31:0]    d_p     [0:ND];
  ers_pkg::side_t d_side  [0:ND];

  assign d_valid[0] = s3_valid;
  assign d_rem[0]   = '0;
  assign d_num[0]   = s3_vsq;
  assign d_p[0]     = s3_p;
  assign d_side[0]  = s3_side;

  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [32:0] sh;
    logic        ge;
    logic [32:0] diff;

    assign sh   = {d_rem[j], d_num[j][55]};
    assign ge   = sh >= {1'b0, d_p[j]};
    assign diff = sh - {1'b0, d_p[j]};

    always_ff @(posedge clk) begin
      if (rst) d_valid[j+1] <= 1'b0;
      else     d_valid[j+1] <= d_valid[j];
    end

    always_ff @(posedge clk) begin
      d_rem[j+1]  <= ge ? diff[31:0] : sh[31:0];
      d_num[j+1]  <= {d_num[j][54:0], ge};
      d_p[j+1]    <= d_p[j];
      d_side[j+1] <= d_side[j];
    end
  end

  // digit-by-digit square root, one root bit per stage
  logic           q_valid [0:NS];
  logic [28:0]    q_rem   [0:NS];
  logic [27:0]    q_root  [0:NS];
  logic [55:0]    q_num   [0:NS];
  ers_pkg::side_t q_side  [0:NS];

  assign q_valid[0] = d_valid[ND];
  assign q_rem[0]   = '0;
  assign q_root[0]  = '0;
  assign q_num[0]   = d_num[ND];
  assign q_side[0]  = d_side[ND];

  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    logic [30:0] cur;
    logic [30:0] trial;
    logic        ge;
    logic [30:0] diff;

    assign cur   = {q_rem[j], q_num[j][55:54]};
    assign trial = {1'b0, q_root[j], 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (rst) q_valid[j+1] <= 1'b0;
      else     q_valid[j+1] <= q_valid[j];
    end

    always_ff @(posedge clk) begin
      q_rem[j+1]  <= ge ? diff[28:0] : cur[28:0];
      q_root[j+1] <= {q_root[j][26:0], ge};
      q_num[j+1]  <= {q_num[j][53:0], 2'b00};
      q_side[j+1] <= q_side[j];
    end
  end

  // blend stage 1: k*I and (1-k)*c
  logic                          m1_valid;
  logic [44:0]                   m1_ki;
  logic signed [2:0][26:0]       m1_mc;
  ers_pkg::side_t                m1_side;
  logic signed [18:0]            one_minus_k;

  assign one_minus_k = $signed({2'b00, ers_pkg::GAIN_ONE}) - $signed({2'b00, emboss_gain});

  always_ff @(posedge clk) begin
    if (rst) m1_valid <= 1'b0;
    else     m1_valid <= q_valid[NS];
  end

  always_ff @(posedge clk) begin
    m1_ki   <= 45'(emboss_gain) * 45'(q_root[NS]);
    for (int c = 0; c < 3; c++) begin
      m1_mc[c] <= 27'(one_minus_k) * 27'($signed({1'b0, q_side[NS].chan[c]}));
    end
    m1_side <= q_side[NS];
  end

  // blend stage 2: k*I*c + (1-k)*c*2^16
  logic                    m2_valid;
  logic signed [2:0][55:0] m2_acc;
  logic signed [2:0][26:0] m2_mc;
  logic                    m2_facing;

  always_ff @(posedge clk) begin
    if (rst) m2_valid <= 1'b0;
    else     m2_valid <= m1_valid;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      m2_acc[c] <= $signed({3'b000, 53'(m1_ki) * 53'(m1_side.chan[c])})
                 + ($signed(56'($signed(m1_mc[c]))) <<< 16);
    end
    m2_mc     <= m1_mc;
    m2_facing <= m1_side.facing;
  end

  // saturation and output register
  logic [2:0][7:0] sat;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (m2_facing) begin
        if (m2_acc[c][55])          sat[c] = 8'd0;
        else if (|m2_acc[c][54:40]) sat[c] = 8'd255;
        else                        sat[c] = m2_acc[c][39:32];
      end else begin
        if (m2_mc[c][26])           sat[c] = 8'd0;
        else if (|m2_mc[c][25:24])  sat[c] = 8'd255;
        else                        sat[c] = m2_mc[c][23:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= m2_valid;
  end

  always_ff @(posedge clk) begin
    out_red      <= sat[0];
    out_green    <= sat[1];
    out_blue     <= sat[2];
    facing_light <= m2_facing;
  end

`ifndef NO_ASSERTIONS
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_shadow_zero_v: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_side.facing |-> s2_v == 28'd0)
    else $error("dividend not cleared for shadowed pixel");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    d_valid[ND] |-> d_rem[ND] < d_p[ND])
    else $error("division remainder out of range");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    q_valid[NS] |-> {1'b0, q_rem[NS]} <= {1'b0, q_root[NS], 1'b0})
    else $error("square root remainder out of range");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    m2_valid |=> done)
    else $error("result strobe lost");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the emboss relief shading core: directed and random pixel
// requests under several gain and light settings, each result checked
// against a bit-exact shading predictor held in the bench.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [7:0] hl, hr, hu, hd, r, g, b;
  } pixel_t;

  typedef struct packed {
    logic [7:0] r, g, b;
    logic       f;
  } shade_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  height_left = '0, height_right = '0, height_up = '0, height_down = '0;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;
  logic        done;
  logic [7:0]  out_red, out_green, out_blue;
  logic        facing_light;

  pixel_t pixel_q[$];
  shade_t shade_q[$];
  longint gain_cur = 32768, lx_cur = 0, ly_cur = 0, lz_cur = 16384;
  int     errors = 0;
  int     burst_left = 0, gap_left = 0, idle_cycles = 0;

  emboss_relief_shading_core u_top (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [7:0] clamp_shift(longint v, int sh);
    longint q;
    if (v < 0) return 8'd0;
    q = v >>> sh;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic shade_t shade_pixel(pixel_t p);
    longint dx, dy, nint, prod, v, iq;
    longint c[3];
    logic [7:0] o[3];
    shade_t s;
    dx = longint'(p.hl) - longint'(p.hr);
    dy = longint'(p.hu) - longint'(p.hd);
    c[0] = p.r; c[1] = p.g; c[2] = p.b;
    nint = -2 * dx * lx_cur - 2 * dy * ly_cur + 4 * lz_cur;
    if (nint >= 0) begin
      prod = (4 + dx * dx) * (4 + dy * dy);
      v = nint * 4;
      iq = longint'(int_sqrt(longint'(v * v) / prod));
      for (int i = 0; i < 3; i++)
        o[i] = clamp_shift(gain_cur * iq * c[i] + (65536 - gain_cur) * c[i] * 65536, 32);
    end else begin
      for (int i = 0; i < 3; i++)
        o[i] = clamp_shift((65536 - gain_cur) * c[i], 16);
    end
    s.r = o[0]; s.g = o[1]; s.b = o[2]; s.f = (nint >= 0);
    return s;
  endfunction

  // request driver, bursts with random gaps
  always @(posedge clk) begin
    pixel_t p;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        shade_q.push_back(shade_pixel({height_left, height_right, height_up,
                                       height_down, in_red, in_green, in_blue}));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          p = pixel_q.pop_front();
          {height_left, height_right, height_up, height_down, in_red, in_green,
           in_blue} <= p;
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    shade_t exp_s;
    if (!rst && done) begin
      if (shade_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result r=%0d g=%0d b=%0d f=%0b",
                                   out_red, out_green, out_blue, facing_light);
      end else begin
        exp_s = shade_q.pop_front();
        if (exp_s != {out_red, out_green, out_blue, facing_light}) begin
          errors++;
          if (errors <= 10)
            $display("exp r=%0d g=%0d b=%0d f=%0b got r=%0d g=%0d b=%0d f=%0b",
                     exp_s.r, exp_s.g, exp_s.b, exp_s.f,
                     out_red, out_green, out_blue, facing_light);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("emboss_relief_shading_core: mismatch");
      $finish;
    end
  end

  task automatic drain();
    while (pixel_q.size() > 0 || shade_q.size() > 0 || start) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_regs(longint gain, longint lx, longint ly, longint lz);
    longint vals[4];
    vals = '{gain, lx, ly, lz};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= ers_pkg::reg_index_t'(2'(i));
      cfg_data <= vals[i][16:0];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
    gain_cur = gain & 64'h1FFFF;
    lx_cur = longint'(signed'(lx[15:0]));
    ly_cur = longint'(signed'(ly[15:0]));
    lz_cur = longint'(signed'(lz[15:0]));
  endtask

  task automatic add_pixel(int hl, int hr, int hu, int hd, int r, int g, int b);
    pixel_t p;
    p = {8'(hl), 8'(hr), 8'(hu), 8'(hd), 8'(r), 8'(g), 8'(b)};
    pixel_q.push_back(p);
  endtask

  task automatic add_random(int n);
    int hl, hu;
    for (int i = 0; i < n; i++) begin
      hl = $urandom_range(0, 255);
      hu = $urandom_range(0, 255);
      add_pixel(hl, ($urandom_range(0, 3) == 0) ? hl : $urandom_range(0, 255),
                hu, ($urandom_range(0, 3) == 0) ? hu : $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  function automatic longint pick_light();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return longint'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings
    add_pixel(0, 0, 0, 0, 255, 255, 255);
    add_pixel(255, 0, 0, 255, 255, 0, 255);
    add_pixel(0, 255, 255, 0, 0, 255, 0);
    add_pixel(170, 85, 85, 170, 170, 85, 1);
    add_pixel(255, 255, 255, 255, 128, 64, 32);
    drain();

    // unit gain, light along x and z; dx of two gives zero intensity
    set_regs(65536, 16384, 0, 16384);
    add_pixel(2, 0, 10, 200, 255, 255, 255);
    add_pixel(100, 98, 0, 255, 200, 100, 50);
    add_pixel(0, 255, 7, 7, 255, 255, 255);
    add_pixel(255, 0, 0, 0, 255, 255, 255);
    add_pixel(1, 0, 0, 0, 255, 128, 3);
    drain();

    // gain above one, lights out of range
    set_regs(131071, -32768, 32767, -32768);
    add_pixel(0, 255, 255, 0, 255, 255, 255);
    add_pixel(255, 0, 0, 255, 255, 255, 255);
    add_pixel(0, 0, 0, 0, 255, 1, 0);
    add_pixel(10, 12, 40, 38, 90, 180, 255);
    drain();

    set_regs(0, -16384, -16384, 16384);
    add_pixel(255, 0, 255, 0, 255, 255, 255);
    add_pixel(0, 255, 0, 255, 255, 255, 255);
    add_pixel(0, 0, 0, 0, 0, 0, 0);
    add_pixel(3, 1, 4, 1, 5, 9, 2);
    drain();

    set_regs(65537, 32767, -32768, 32767);
    add_pixel(0, 1, 1, 0, 255, 255, 255);
    add_pixel(128, 127, 64, 65, 200, 200, 200);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph % 3)
        0: set_regs($urandom_range(0, 65536), pick_light(), pick_light(), pick_light());
        1: set_regs($urandom_range(0, 131071), pick_light(), pick_light(), pick_light());
        default: set_regs(65536, pick_light(), pick_light(), pick_light());
      endcase
      add_random(25);
      drain();
      add_random(30);
      drain();
    end

    if (errors == 0) $display("emboss_relief_shading_core: match");
    else $display("emboss_relief_shading_core: mismatch");
    $finish;
  end
endmodule
